>>> rtl/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// shared constants, types and fixed-point helpers of the perceptron trainer
// ----------------------------------------------------------------------------
`default_nettype none
package mbp_pkg;

    localparam int NI = 2;
    localparam int NH = 2;
    localparam int NO = 1;
    localparam int NL = 3;
    localparam int NW = NH * NI + (NL - 2) * NH * NH + NO * NH;
    localparam int NB = (NL - 1) * NH + NO;

    localparam logic [11:0] RATE_RESET = 12'd410;
    localparam logic [31:0] EXP_STEP   = 32'd4034748382;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_TRAIN = 1'b1
    } t_op;

    typedef struct packed {
        logic        start;
        logic [45:0] num;
        logic [33:0] den;
    } t_div_req;

    function automatic int lsize(input int k);
        return (k == NL - 1) ? NO : NH;
    endfunction

    function automatic int lin(input int k);
        return (k == 0) ? NI : NH;
    endfunction

    function automatic int loff(input int k);
        return k * NH;
    endfunction

    function automatic int woff(input int k);
        return (k == 0) ? 0 : NH * NI + (k - 1) * NH * NH;
    endfunction

    // product shifted right 12, floor
    function automatic logic signed [23:0] asr12(input logic signed [33:0] p);
        logic signed [21:0] s;
        s = $signed(p[33:12]);
        return 24'(s);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sh7fff;
        end else if (v < -24'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/mlp_backprop_train_step_core.sv
// ----------------------------------------------------------------------------
// mlp_backprop_train_step_core
// online backpropagation trainer for a 2-2-2-1 sigmoid perceptron in Q4.12
// ----------------------------------------------------------------------------
// One request is either a load (writes one weight or bias at acceptance)
// or a train step (forward pass, backpropagated deltas, then a weight update
// of rate*delta*input), each answered by one result holding the output
// activation and output delta (zeros for a load). All train-step products go
// through one shared 17x17 multiplier under a state sequencer, which runs the
// forward pass, the deltas, the update and the result post in that order and
// then returns to idle, where the next request can be taken.
// After reset the sigmoid table (256 entries, one ram) is built by a
// restoring divider and a 32x32 exponent multiplier; requests are held off
// until then, config writes are taken anytime.
// A finished result sits in an output register; while it is stalled the next
// request is held off as well.
// ----------------------------------------------------------------------------
`default_nettype none
module mlp_backprop_train_step_core
    import mbp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [11:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_op,
    input  wire logic signed [15:0] i_sample_a,
    input  wire logic signed [15:0] i_sample_b,
    input  wire logic [12:0]        i_target,
    input  wire logic [3:0]         i_param_index,
    input  wire logic signed [15:0] i_param_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [12:0]             o_out_activation,
    output logic signed [13:0]      o_out_delta
);

    typedef enum logic [22:0] {
        S_INIT_P  = 23'h000001,
        S_INIT_PW = 23'h000002,
        S_INIT_N  = 23'h000004,
        S_INIT_NW = 23'h000008,
        S_INIT_E  = 23'h000010,
        S_IDLE    = 23'h000020,
        S_F_BIAS  = 23'h000040,
        S_F_MUL   = 23'h000080,
        S_F_ACC   = 23'h000100,
        S_F_LUT   = 23'h000200,
        S_F_WB    = 23'h000400,
        S_D1      = 23'h000800,
        S_D2      = 23'h001000,
        S_D3      = 23'h002000,
        S_D4      = 23'h004000,
        S_H_CLR   = 23'h008000,
        S_H_MUL   = 23'h010000,
        S_H_ACC   = 23'h020000,
        S_U_RD    = 23'h040000,
        S_U_RD2   = 23'h080000,
        S_U_MUL   = 23'h100000,
        S_U_ACC   = 23'h200000,
        S_DONE    = 23'h400000
    } t_state;

    // sequencer and datapath registers
    t_state             r_state, n_state;
    logic [1:0]         r_k, n_k;       // layer
    logic [1:0]         r_i, n_i;       // neuron in layer
    logic [1:0]         r_j, n_j;       // input / next-layer neuron
    logic signed [15:0] r_w   [NW];
    logic signed [15:0] n_w   [NW];
    logic signed [15:0] r_b   [NB];
    logic signed [15:0] n_b   [NB];
    logic signed [15:0] r_act [NB];
    logic signed [15:0] n_act [NB];
    logic signed [15:0] r_dl  [NB];
    logic signed [15:0] n_dl  [NB];
    logic signed [15:0] r_x   [NI];
    logic signed [15:0] n_x   [NI];
    logic [12:0]        r_t, n_t;
    logic signed [23:0] r_acc, n_acc;
    logic signed [16:0] r_der, n_der;
    logic signed [16:0] r_rd, n_rd;
    logic [11:0]        r_rate;
    logic               r_ov, n_ov;
    logic [12:0]        r_oa, n_oa;
    logic signed [13:0] r_od, n_od;

    // table build registers
    logic [7:0]         r_m, n_m;
    logic [32:0]        r_e, n_e;

    // shared multiplier
    logic               mul_en;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod;
    logic signed [23:0] prod_s;

    // table ram and divider
    logic               ram_we;
    logic [7:0]         ram_waddr, ram_raddr;
    logic [12:0]        ram_wdata, ram_rdata;
    t_div_req           div_req;
    logic               div_done;
    logic [12:0]        div_q;
    logic [33:0]        den;
    logic [63:0]        e_prod;

    // address decode
    logic [3:0]         fw_idx, hw_idx;
    logic [2:0]         n_idx, p_idx, nx_idx;
    logic               last_j_f, last_j_h, last_i;
    logic signed [15:0] f_src, a_cur, s_sat;
    logic               in_acc, out_acc;

    always_comb begin
        int k, i, j;
        k = int'(r_k);
        i = int'(r_i);
        j = int'(r_j);
        fw_idx   = 4'(woff(k) + i * lin(k) + j);
        hw_idx   = 4'(woff(k + 1) + j * lin(k + 1) + i);
        n_idx    = 3'(loff(k) + i);
        p_idx    = (k == 0) ? 3'd0 : 3'(loff(k - 1) + j);
        nx_idx   = 3'(loff(k + 1) + j);
        last_j_f = (j == lin(k) - 1);
        last_j_h = (j == lsize(k + 1) - 1);
        last_i   = (i == lsize(k) - 1);
    end

    assign f_src  = (r_k == 2'd0) ? r_x[r_j[0]] : r_act[p_idx];
    assign a_cur  = r_act[n_idx];
    assign s_sat  = sat16(r_acc);
    assign prod_s = asr12(prod);

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_ov && !i_out_stall;

    // table build arithmetic
    assign den    = 34'h1_0000_0000 + 34'(r_e);
    assign e_prod = 64'(r_e[31:0]) * 64'(EXP_STEP) + 64'h8000_0000;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_i       = r_i;
        n_j       = r_j;
        n_w       = r_w;
        n_b       = r_b;
        n_act     = r_act;
        n_dl      = r_dl;
        n_x       = r_x;
        n_t       = r_t;
        n_acc     = r_acc;
        n_der     = r_der;
        n_rd      = r_rd;
        n_m       = r_m;
        n_e       = r_e;
        n_ov      = out_acc ? 1'b0 : r_ov;
        n_oa      = r_oa;
        n_od      = r_od;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = div_q;
        ram_raddr = {~s_sat[15], s_sat[14:8]};
        div_req   = '0;

        unique case (r_state)
            // sigmoid table build: positive and negative halves per power
            S_INIT_P: begin
                div_req.start = 1'b1;
                div_req.num   = 46'h1000_0000_0000 + 46'(den >> 1);
                div_req.den   = den;
                n_state       = S_INIT_PW;
            end
            S_INIT_PW: begin
                if (div_done) begin
                    ram_we    = !r_m[7];
                    ram_waddr = {1'b1, r_m[6:0]};
                    n_state   = (r_m == 8'd0) ? S_INIT_E : S_INIT_N;
                end
            end
            S_INIT_N: begin
                div_req.start = 1'b1;
                div_req.num   = 46'({r_e, 12'd0}) + 46'(den >> 1);
                div_req.den   = den;
                n_state       = S_INIT_NW;
            end
            S_INIT_NW: begin
                if (div_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = 8'(9'd128 - 9'(r_m));
                    n_state   = S_INIT_E;
                end
            end
            S_INIT_E: begin
                if (r_m == 8'd128) begin
                    n_state = S_IDLE;
                end else begin
                    n_e     = (r_m == 8'd0) ? 33'(EXP_STEP) : 33'(e_prod >> 32);
                    n_m     = r_m + 8'd1;
                    n_state = S_INIT_P;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (t_op'(i_op) == OP_LOAD) begin
                        if (i_param_index < 4'(NW)) begin
                            n_w[i_param_index] = i_param_value;
                        end else if (i_param_index < 4'(NW + NB)) begin
                            n_b[3'(i_param_index - 4'(NW))] = i_param_value;
                        end
                        n_ov = 1'b1;
                        n_oa = '0;
                        n_od = '0;
                    end else begin
                        n_x[0]  = i_sample_a;
                        n_x[1]  = i_sample_b;
                        n_t     = i_target;
                        n_k     = '0;
                        n_i     = '0;
                        n_state = S_F_BIAS;
                    end
                end
            end
            // forward pass
            S_F_BIAS: begin
                n_acc   = 24'(r_b[n_idx]);
                n_j     = '0;
                n_state = S_F_MUL;
            end
            S_F_MUL: begin
                mul_en  = 1'b1;
                mul_a   = 17'(r_w[fw_idx]);
                mul_b   = 17'(f_src);
                n_state = S_F_ACC;
            end
            S_F_ACC: begin
                n_acc = r_acc + prod_s;
                if (last_j_f) begin
                    n_state = S_F_LUT;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_F_MUL;
                end
            end
            S_F_LUT: begin
                n_state = S_F_WB;
            end
            S_F_WB: begin
                n_act[n_idx] = 16'(ram_rdata);
                n_i          = last_i ? 2'd0 : r_i + 2'd1;
                n_state      = S_F_BIAS;
                if (last_i) begin
                    if (int'(r_k) == NL - 1) begin
                        n_state = S_D1;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            // delta of one neuron: derivative, then scale
            S_D1: begin
                mul_en  = 1'b1;
                mul_a   = 17'(a_cur);
                mul_b   = 17'sd4096 - 17'(a_cur);
                n_state = S_D2;
            end
            S_D2: begin
                n_der   = prod_s[16:0];
                n_state = S_D3;
            end
            S_D3: begin
                mul_en  = 1'b1;
                mul_a   = (int'(r_k) == NL - 1) ?
                          17'($signed({4'd0, r_t})) - 17'(a_cur) : 17'(s_sat);
                mul_b   = r_der;
                n_state = S_D4;
            end
            S_D4: begin
                n_dl[n_idx] = sat16(prod_s);
                if (last_i) begin
                    n_i = '0;
                    if (r_k == 2'd0) begin
                        n_state = S_U_RD;
                    end else begin
                        n_k     = r_k - 2'd1;
                        n_state = S_H_CLR;
                    end
                end else begin
                    n_i     = r_i + 2'd1;
                    n_state = (int'(r_k) == NL - 1) ? S_D1 : S_H_CLR;
                end
            end
            // backpropagated sum over the next layer
            S_H_CLR: begin
                n_acc   = '0;
                n_j     = '0;
                n_state = S_H_MUL;
            end
            S_H_MUL: begin
                mul_en  = 1'b1;
                mul_a   = 17'(r_dl[nx_idx]);
                mul_b   = 17'(r_w[hw_idx]);
                n_state = S_H_ACC;
            end
            S_H_ACC: begin
                n_acc = r_acc + prod_s;
                if (last_j_h) begin
                    n_state = S_D1;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = S_H_MUL;
                end
            end
            // weight update
            S_U_RD: begin
                mul_en  = 1'b1;
                mul_a   = 17'($signed({5'd0, r_rate}));
                mul_b   = 17'(r_dl[n_idx]);
                n_state = S_U_RD2;
            end
            S_U_RD2: begin
                n_rd    = prod_s[16:0];
                n_j     = '0;
                n_state = S_U_MUL;
            end
            S_U_MUL: begin
                mul_en  = 1'b1;
                mul_a   = r_rd;
                mul_b   = 17'(f_src);
                n_state = S_U_ACC;
            end
            S_U_ACC: begin
                n_w[fw_idx] = sat16(24'(r_w[fw_idx]) + prod_s);
                if (!last_j_f) begin
                    n_j     = r_j + 2'd1;
                    n_state = S_U_MUL;
                end else if (!last_i) begin
                    n_i     = r_i + 2'd1;
                    n_state = S_U_RD;
                end else if (int'(r_k) != NL - 1) begin
                    n_i     = '0;
                    n_k     = r_k + 2'd1;
                    n_state = S_U_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_oa    = r_act[loff(NL - 1)][12:0];
                    n_od    = r_dl[loff(NL - 1)][13:0];
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_P;
            r_m     <= '0;
            r_e     <= 33'h1_0000_0000;
            r_ov    <= 1'b0;
            r_rate  <= RATE_RESET;
            r_w     <= '{default: '0};
            r_b     <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_m     <= n_m;
            r_e     <= n_e;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            r_w <= n_w;
            r_b <= n_b;
        end
        r_k   <= n_k;
        r_i   <= n_i;
        r_j   <= n_j;
        r_act <= n_act;
        r_dl  <= n_dl;
        r_x   <= n_x;
        r_t   <= n_t;
        r_acc <= n_acc;
        r_der <= n_der;
        r_rd  <= n_rd;
        r_oa  <= n_oa;
        r_od  <= n_od;
    end

    mbp_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    mbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    mbp_ram #(
        .WIDTH (13),
        .DEPTH (256)
    ) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request stalled whenever the sequencer is busy or the result slot is blocked
    assign o_in_stall       = (r_state != S_IDLE) || (r_ov && i_out_stall);
    assign o_out_valid      = r_ov;
    assign o_out_activation = r_oa;
    assign o_out_delta      = r_od;

`ifndef SYNTH
    // an accepted request either starts training or posts a load result
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE) || o_out_valid)
        else $error("accepted request made no progress");

    // table lookup data is used in the cycle after its address is presented
    a_lut_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F_WB) |-> ($past(r_state) == S_F_LUT))
        else $error("sigmoid read-back out of step");

    // a finished train step posts its result when the slot is free
    a_done_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !(r_ov && i_out_stall)) |=> o_out_valid)
        else $error("train result not posted");
`endif

endmodule
`default_nettype wire

>>> rtl/mbp_ram.sv
// ----------------------------------------------------------------------------
// mbp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module mbp_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/mbp_div.sv
// ----------------------------------------------------------------------------
// mbp_div
// restoring divider, one quotient bit per cycle, 13-bit quotient
// ----------------------------------------------------------------------------
`default_nettype none
module mbp_div
    import mbp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_div_req    i_req,
    output logic             o_done,
    output logic [12:0]      o_q
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [45:0] r_rem, n_rem;
    logic [33:0] r_den, n_den;
    logic [12:0] r_q, n_q;
    logic [45:0] shifted;

    assign shifted = 46'(r_den) << r_cnt;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd12;
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_q    = '0;
        end else if (r_busy) begin
            if (r_rem >= shifted) begin
                n_rem        = r_rem - shifted;
                n_q[r_cnt]   = 1'b1;
            end
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule
`default_nettype wire

>>> rtl/mbp_mul.sv
// ----------------------------------------------------------------------------
// mbp_mul
// shared 17x17 signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none
module mbp_mul (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [16:0] i_a,
    input  wire logic signed [16:0] i_b,
    output logic signed      [33:0] o_prod
);

    logic signed [33:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

>>> tb/sv/mlp_backprop_train_step_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_backprop_train_step_core_checker
// watches the request, result and config ports, predicts each result with its
// own fixed-point copy of the network and compares it with what comes out
// ----------------------------------------------------------------------------
module mlp_backprop_train_step_core_checker
    import mbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [11:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_op,
    input  logic signed [15:0] i_sample_a,
    input  logic signed [15:0] i_sample_b,
    input  logic [12:0]        i_target,
    input  logic [3:0]         i_param_index,
    input  logic signed [15:0] i_param_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [12:0]        i_out_activation,
    input  logic signed [13:0] i_out_delta,
    output int                 o_fail_count,
    output int                 o_pending
);

    int            weights[NW];
    int            biases[NB];
    int            neuron_act[NB];
    int            neuron_delta[NB];
    int            sigmoid_lut[256];
    logic [11:0]   step_rate;
    logic [12:0]   act_queue[$];
    logic [13:0]   delta_queue[$];

    function automatic longint floor12(input longint v);
        return v >>> 12;
    endfunction

    function automatic int clip16(input longint v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return int'(v);
    endfunction

    // powers of e^-1/16 in Q32, then 4096 * sigma for each 1/16 step
    function automatic void build_sigmoid();
        longint unsigned pw[129];
        longint unsigned den;
        longint unsigned num;
        int mm;
        pw[0] = 64'd1 << 32;
        for (int m = 1; m <= 128; m++) begin
            pw[m] = (pw[m-1] * 64'(EXP_STEP) + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < 256; i++) begin
            mm  = (i >= 128) ? i - 128 : 128 - i;
            den = (64'd1 << 32) + pw[mm];
            num = (i >= 128) ? (64'd1 << 44) : 64'd4096 * pw[mm];
            sigmoid_lut[i] = int'((num + den / 2) / den);
        end
    endfunction

    function automatic void train_sample(input logic signed [15:0] sa,
                                         input logic signed [15:0] sb,
                                         input logic [12:0] tg,
                                         output logic [12:0] exp_act,
                                         output logic [13:0] exp_delta);
        int     x[NI];
        int     lofs[NL];
        int     wofs[NL];
        int     ls, li, src, a, w;
        longint s, rd;
        lofs[0] = 0;
        wofs[0] = 0;
        for (int k = 1; k < NL; k++) begin
            lofs[k] = lofs[k-1] + NH;
            wofs[k] = wofs[k-1] + NH * ((k == 1) ? NI : NH);
        end
        for (int j = 0; j < NI; j++) x[j] = 0;
        x[0] = sa;
        if (NI > 1) x[1] = sb;
        // forward
        for (int k = 0; k < NL; k++) begin
            ls = (k == NL - 1) ? NO : NH;
            li = (k == 0) ? NI : NH;
            for (int i = 0; i < ls; i++) begin
                s = biases[lofs[k] + i];
                for (int j = 0; j < li; j++) begin
                    src = (k == 0) ? x[j] : neuron_act[lofs[k-1] + j];
                    s += floor12(longint'(weights[wofs[k] + i*li + j]) * src);
                end
                neuron_act[lofs[k] + i] = sigmoid_lut[((clip16(s) + 32768) >> 8) & 255];
            end
        end
        // backward, with the old weights
        for (int i = 0; i < NO; i++) begin
            a = neuron_act[lofs[NL-1] + i];
            neuron_delta[lofs[NL-1] + i] =
                clip16(floor12((longint'(tg) - a) * floor12(longint'(a) * (4096 - a))));
        end
        for (int k = NL - 2; k >= 0; k--) begin
            ls = (k + 1 == NL - 1) ? NO : NH;
            for (int j = 0; j < NH; j++) begin
                s = 0;
                for (int m = 0; m < ls; m++) begin
                    s += floor12(longint'(neuron_delta[lofs[k+1] + m]) *
                                 weights[wofs[k+1] + m*NH + j]);
                end
                a = neuron_act[lofs[k] + j];
                neuron_delta[lofs[k] + j] =
                    clip16(floor12(longint'(clip16(s)) * floor12(longint'(a) * (4096 - a))));
            end
        end
        // update
        for (int k = 0; k < NL; k++) begin
            ls = (k == NL - 1) ? NO : NH;
            li = (k == 0) ? NI : NH;
            for (int i = 0; i < ls; i++) begin
                rd = floor12(longint'(step_rate) * neuron_delta[lofs[k] + i]);
                for (int j = 0; j < li; j++) begin
                    src = (k == 0) ? x[j] : neuron_act[lofs[k-1] + j];
                    w   = wofs[k] + i*li + j;
                    weights[w] = clip16(longint'(weights[w]) + floor12(rd * src));
                end
            end
        end
        exp_act   = 13'(neuron_act[lofs[NL-1]]);
        exp_delta = 14'(neuron_delta[lofs[NL-1]]);
    endfunction

    initial begin
        build_sigmoid();
        o_fail_count = 0;
    end

    assign o_pending = act_queue.size();

    always @(posedge i_clk) begin
        logic [12:0] ea;
        logic [13:0] ed;
        if (!i_rst_n) begin
            for (int i = 0; i < NW; i++) weights[i] = 0;
            for (int i = 0; i < NB; i++) biases[i] = 0;
            step_rate = RATE_RESET;
            act_queue.delete();
            delta_queue.delete();
        end else begin
            if (i_cfg_we) step_rate = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_op == OP_TRAIN) begin
                    train_sample(i_sample_a, i_sample_b, i_target, ea, ed);
                end else begin
                    if (i_param_index < NW) begin
                        weights[i_param_index] = i_param_value;
                    end else if (i_param_index < NW + NB) begin
                        biases[i_param_index - NW] = i_param_value;
                    end
                    ea = '0;
                    ed = '0;
                end
                act_queue.push_back(ea);
                delta_queue.push_back(ed);
            end
            if (i_out_valid && !i_out_stall) begin
                if (act_queue.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count++;
                end else begin
                    ea = act_queue.pop_front();
                    ed = delta_queue.pop_front();
                    if (i_out_activation !== ea) begin
                        $error("out_activation expected %0d actual %0d", ea, i_out_activation);
                        o_fail_count++;
                    end
                    if (i_out_delta !== ed) begin
                        $error("out_delta expected %0d actual %0d",
                               $signed(ed), i_out_delta);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/mlp_backprop_train_step_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_backprop_train_step_core_test
// drives load and train requests through the perceptron trainer under four
// idling mixes and several learning rates; the checker scores every result
// ----------------------------------------------------------------------------
module mlp_backprop_train_step_core_test;
    import mbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;   // covers the table build after reset
    localparam int DRAIN_CYCLES   = 300;     // extra wait after the last expected result

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [11:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_op;
    logic signed [15:0] i_sample_a;
    logic signed [15:0] i_sample_b;
    logic [12:0]        i_target;
    logic [3:0]         i_param_index;
    logic signed [15:0] i_param_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [12:0]        o_out_activation;
    logic signed [13:0] o_out_delta;

    int fail_count;
    int pending;
    int idle_pct;       // sender gap chance per cycle
    int stall_pct;      // receiver stall chance per cycle
    int quiet_cycles;

    mlp_backprop_train_step_core i_dut (.*);

    mlp_backprop_train_step_core_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid, .i_in_stall(o_in_stall),
        .i_op, .i_sample_a, .i_sample_b, .i_target, .i_param_index, .i_param_value,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_out_activation(o_out_activation), .i_out_delta(o_out_delta),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("mlp_backprop_train_step_core_test: FAIL");
            $finish;
        end
    end

    // one request: random gaps, then hold until the block takes it
    task automatic send_request(input t_op op, input logic signed [15:0] sa,
                                input logic signed [15:0] sb, input logic [12:0] tg,
                                input logic [3:0] pidx, input logic signed [15:0] pval);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid    <= 1'b0;
            i_op          <= 1'($urandom);
            i_sample_a    <= 16'($urandom);
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_sample_a    <= sa;
        i_sample_b    <= sb;
        i_target      <= tg;
        i_param_index <= pidx;
        i_param_value <= pval;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) begin
                @(posedge i_clk);
                break;
            end
        end
    endtask

    function automatic logic signed [15:0] rand_q412();
        if ($urandom_range(3) == 0) begin
            return 16'($urandom);
        end
        return 16'($signed($urandom_range(16384)) - 8192);
    endfunction

    function automatic logic [12:0] rand_target();
        if ($urandom_range(7) == 0) begin
            return 13'($urandom);
        end
        return 13'($urandom_range(4096));
    endfunction

    // learning rate only changes once every result is out
    task automatic set_rate(input logic [11:0] rate);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        for (int n = 0; n < n_items; n++) begin
            // mostly training, with occasional parameter loads (some out of range)
            if ($urandom_range(9) == 0) begin
                send_request(OP_LOAD, rand_q412(), rand_q412(), rand_target(),
                             4'($urandom), rand_q412());
            end else begin
                send_request(OP_TRAIN, rand_q412(), rand_q412(), rand_target(),
                             4'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_op          = OP_LOAD;
        i_sample_a    = '0;
        i_sample_b    = '0;
        i_target      = '0;
        i_param_index = '0;
        i_param_value = '0;
        i_out_stall   = 1'b0;
        quiet_cycles  = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: train on the reset network, then load every parameter
        send_request(OP_TRAIN, 16'sh7fff, 16'sh8000, 13'd4096, 4'd0, 16'sd0);
        for (int p = 0; p < NW + NB; p++) begin
            send_request(OP_LOAD, 16'sd0, 16'sd0, 13'd0, 4'(p),
                         (p % 2) ? 16'sh7fff : 16'sh8000);
        end
        // index past the last bias is ignored
        send_request(OP_LOAD, 16'sd0, 16'sd0, 13'd0, 4'd15, 16'sh1234);
        send_request(OP_TRAIN, 16'sh8000, 16'sh7fff, 13'd0, 4'd0, 16'sd0);
        send_request(OP_TRAIN, 16'sd0, 16'sd0, 13'h1fff, 4'd0, 16'sd0);   // target above one
        send_request(OP_TRAIN, 16'sh7fff, 16'sh7fff, 13'd4096, 4'd0, 16'sd0);
        send_request(OP_TRAIN, 16'sh1000, -16'sh1000, 13'd2048, 4'd0, 16'sd0);

        // random phases, one per idling mix, each with its own rate
        set_rate(12'd4095);
        random_phase(400);
        set_rate(12'd0);
        idle_pct = 83;
        random_phase(400);
        set_rate(12'($urandom));
        idle_pct  = 0;
        stall_pct = 83;
        random_phase(400);
        set_rate(12'd410);
        idle_pct  = 26;
        stall_pct = 26;
        random_phase(430);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("mlp_backprop_train_step_core_test: PASS");
        end else begin
            $display("mlp_backprop_train_step_core_test: FAIL");
        end
        $finish;
    end

endmodule

>>> mlp_backprop_train_step_core.f
rtl/mbp_pkg.sv
rtl/mbp_ram.sv
rtl/mbp_div.sv
rtl/mbp_mul.sv
rtl/mlp_backprop_train_step_core.sv
tb/sv/mlp_backprop_train_step_core_checker.sv
tb/sv/mlp_backprop_train_step_core_test.sv
